/* rtl/nmhr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmhr_pkg: shared types for the next minimal-height rational block
// Holds the status bundle that the gcd unit returns to the sequencer.
// ----------------------------------------------------------------------------
package nmhr_pkg;

  typedef struct packed {
    logic done;     // the gcd run has ended this cycle
    logic coprime;  // the two operands share no factor
  } gcd_status_t;

endpackage

/* rtl/nmhr_gcd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmhr_gcd: iterative binary coprimality test
// One compare and one subtractor, used once a cycle, reduce the operand pair
// until one of them is zero, when the other holds the gcd, or both are even.
// ----------------------------------------------------------------------------
module nmhr_gcd #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [WIDTH-1:0]     a_in,
  input  logic [WIDTH-1:0]     b_in,
  output nmhr_pkg::gcd_status_t status
);

  logic             running;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic             a_zero;
  logic             b_zero;
  logic             both_even;
  logic             finish;
  logic             ge;
  logic [WIDTH-1:0] big;
  logic [WIDTH-1:0] sml;
  logic [WIDTH-1:0] diff;

  assign a_zero    = (a == '0);
  assign b_zero    = (b == '0);
  assign both_even = !a[0] && !b[0];
  assign finish    = running && (a_zero || b_zero || both_even);

  // The shared step: larger minus smaller.
  assign ge   = (a >= b);
  assign big  = ge ? a : b;
  assign sml  = ge ? b : a;
  assign diff = big - sml;

  // With a zero operand the gcd is the other one; two even operands share
  // the factor two. Otherwise at least one operand is odd, so halving the
  // even one keeps the gcd.
  always_comb begin
    status.done    = finish;
    status.coprime = (a_zero || b_zero) && ((a | b) == WIDTH'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (go) begin
      running <= 1'b1;
    end else if (finish) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a <= a_in;
      b <= b_in;
    end else if (running && !finish) begin
      if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (ge) begin
        a <= diff;
      end else begin
        b <= diff;
      end
    end
  end

endmodule

/* rtl/next_minimal_height_rational_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_minimal_height_rational_top: next fraction in minimal-height order
// Sequencer that steps the denominator candidate and runs the shared gcd
// unit on each one until one coprime to the numerator is found or none is left.
// ----------------------------------------------------------------------------
// A proper nonzero fraction is answered from the check state with no search;
// otherwise each candidate tried takes a check and a gcd run (its subtract and
// shift loop); if none below the numerator fits, the result is 1/(frac_num+1).
// Throughput: one request at a time; busy stays high until the result shows.
// The result is shown for one cycle with done and cannot be held off.
// Reset (rst, synchronous) returns the sequencer to idle and drops done.
module next_minimal_height_rational_top #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] frac_num,
  input  logic [WIDTH-1:0] frac_den,
  output logic             done,
  output logic [WIDTH-1:0] next_num,
  output logic [WIDTH:0]   next_den
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_GCD   = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [WIDTH-1:0]      p;
  logic [WIDTH-1:0]      q;
  logic                  gcd_go;
  nmhr_pkg::gcd_status_t gcd_st;
  logic                  swap_case;
  logic                  more;
  logic                  emit_swap;
  logic                  emit_step;

  assign busy      = (state != S_IDLE);
  assign swap_case = (p != '0) && (p < q);
  assign more      = (q < p);

  always_comb begin
    state_next = state;
    gcd_go     = 1'b0;
    emit_swap  = 1'b0;
    emit_step  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (swap_case) begin
          emit_swap  = 1'b1;
          state_next = S_IDLE;
        end else if (more) begin
          gcd_go     = 1'b1;
          state_next = S_GCD;
        end else begin
          emit_step  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_GCD: begin
        if (gcd_st.done) begin
          if (gcd_st.coprime) begin
            emit_swap  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit_swap || emit_step;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      p <= frac_num;
      q <= frac_den;
    end else if (gcd_go) begin
      q <= q + WIDTH'(1);
    end
    if (emit_swap) begin
      next_num <= q;
      next_den <= {1'b0, p};
    end else if (emit_step) begin
      next_num <= WIDTH'(1);
      next_den <= {1'b0, p} + (WIDTH+1)'(1);
    end
  end

  // The candidate is incremented in the same cycle as the launch, so the
  // unit is given the incremented value directly.
  nmhr_gcd #(
    .WIDTH (WIDTH)
  ) u_gcd (
    .clk    (clk),
    .rst    (rst),
    .go     (gcd_go),
    .a_in   (p),
    .b_in   (q + WIDTH'(1)),
    .status (gcd_st)
  );

endmodule

/* rtl/nmhr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmhr_checker: port-level checks for the next minimal-height rational block
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module nmhr_checker #(
  parameter int WIDTH = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [WIDTH-1:0] frac_num,
  input logic [WIDTH-1:0] frac_den,
  input logic             done,
  input logic [WIDTH-1:0] next_num,
  input logic [WIDTH:0]   next_den
);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted request");

  // A result is shown only once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // The denominator of a result is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (next_den != '0))
    else $error("result with zero denominator");

  // A nonzero proper fraction is inverted from the check state, done registered.
  a_invert: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (frac_num != '0) && (frac_num < frac_den)
    |=> ##1 done && (next_num == $past(frac_den, 2))
            && (next_den == {1'b0, $past(frac_num, 2)}))
    else $error("proper fraction not inverted");

endmodule

bind next_minimal_height_rational_top nmhr_checker #(
  .WIDTH (WIDTH)
) u_nmhr_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .frac_num (frac_num),
  .frac_den (frac_den),
  .done     (done),
  .next_num (next_num),
  .next_den (next_den)
);
